### hw/rtl/ffra_pkg.sv
// ----------------------------------------------------------------------------
// ffra_pkg: shared types and constants
// Request/result payloads, mode and status codes, sequencer states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package ffra_pkg;

    localparam int TOTAL_SLOTS_DEF = 65536;
    localparam int MAX_RUNS_DEF    = 64;
    localparam int BEGIN_W         = 16;
    localparam int LEN_W           = 17;

    localparam logic [1:0] MODE_ALLOC   = 2'd0;
    localparam logic [1:0] MODE_RELEASE = 2'd1;
    localparam logic [1:0] MODE_CLEAR   = 2'd2;
    localparam logic [1:0] MODE_UNDEF   = 2'd3;

    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_REJECT = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] release_start;
        logic [16:0] slot_count;
    } req_t;

    typedef struct packed {
        logic [15:0] granted_start;
        logic [1:0]  status;
    } rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_CHK,
        S_PREV,
        S_SHL_RD,
        S_SHL_WR,
        S_SHR_RD,
        S_SHR_WR,
        S_OUT
    } state_t;

endpackage
`default_nettype wire

### hw/rtl/ffra_table.sv
// ----------------------------------------------------------------------------
// ffra_table: run table memory
// Begin/length storage, one write port and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ffra_table #(
    parameter int MAX_RUNS = ffra_pkg::MAX_RUNS_DEF,
    localparam int AW = $clog2(MAX_RUNS)
) (
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [AW-1:0]        waddr,
    input  wire logic [15:0]          wbegin,
    input  wire logic [16:0]          wlen,
    input  wire logic [AW-1:0]        raddr,
    output logic      [15:0]          rbegin,
    output logic      [16:0]          rlen
);
    logic [32:0] mem [MAX_RUNS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= {wbegin, wlen};
        end
        {rbegin, rlen} <= mem[raddr];
    end
endmodule
`default_nettype wire

### hw/rtl/first_fit_run_allocator_unit.sv
// ----------------------------------------------------------------------------
// first_fit_run_allocator_unit: first-fit free-run allocator
// Address-sorted free-run table with first-fit carve and coalescing release.
// ----------------------------------------------------------------------------
//  channel | direction | payload   | handshake
//  req     | in        | ffra req_t| req_valid / req_ready
//  rsp     | out       | ffra rsp_t| rsp_valid / rsp_ready
//
//  One request at a time. A scan walks the table entry by entry, a read state
//  then a check state each, through the single memory read port and a shared
//  adder; shifts on insert or remove move one entry per read and write state.
//  Clear rewrites entry 0 and resets the run count in the accept cycle and
//  offers its result the next cycle (entries past the count are never read).
//  After reset entry 0 is loaded with the full run in the first cycle;
//  requests are taken from the next cycle on. req_ready stays low from
//  accept until the result is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module first_fit_run_allocator_unit #(
    parameter int TOTAL_SLOTS = ffra_pkg::TOTAL_SLOTS_DEF,
    parameter int MAX_RUNS    = ffra_pkg::MAX_RUNS_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_ready,
    input  wire ffra_pkg::req_t req,
    output logic                rsp_valid,
    input  wire logic           rsp_ready,
    output ffra_pkg::rsp_t      rsp
);
    localparam int AW = $clog2(MAX_RUNS);
    localparam int CW = AW + 1;
    localparam logic [16:0] FULL_LEN = 17'(TOTAL_SLOTS);
    localparam logic [CW-1:0] ONE = CW'(1);
    localparam logic [CW-1:0] MAXC = CW'(MAX_RUNS);

    ffra_pkg::state_t state_reg, state_next;
    ffra_pkg::req_t   req_reg, req_next;
    logic [CW-1:0] total_reg, total_next;
    logic [CW-1:0] idx_reg, idx_next;      // scan / shift position
    logic [CW-1:0] pos_reg, pos_next;      // insert point
    logic [15:0]   pb_reg, pb_next;        // previous entry begin
    logic [16:0]   pl_reg, pl_next;        // previous entry length
    logic [15:0]   nb_reg, nb_next;        // entry at insert point
    logic [16:0]   nl_reg, nl_next;
    ffra_pkg::rsp_t rsp_reg, rsp_next;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [15:0]   wbegin, rbegin;
    logic [16:0]   wlen, rlen;

    // table after reset: entry 0 is written by a one-shot pass
    logic init_done_reg;

    // shared arithmetic
    logic [17:0] sum_a, sum_b, sum_y;
    assign sum_y = sum_a + sum_b;
    function automatic logic [16:0] sat(input logic [17:0] v);
        sat = v[17] ? 17'h1FFFF : v[16:0];
    endfunction

    // carve in CHK, previous-run end everywhere else
    always_comb
    begin
        sum_a = {2'b0, pb_reg};
        sum_b = {1'b0, pl_reg};
        if (state_reg == ffra_pkg::S_CHK)
        begin
            sum_a = {2'b0, rbegin};
            sum_b = {1'b0, req_reg.slot_count};
        end
    end

    // touch tests for a release, valid in PREV
    logic [17:0] rel_end;
    logic        nxt_hit, prv_hit;
    assign rel_end = {2'b0, req_reg.release_start} + {1'b0, req_reg.slot_count};
    assign nxt_hit = (pos_reg < total_reg) && (rel_end == {2'b0, nb_reg});
    assign prv_hit = (pos_reg != '0) && (sum_y == {2'b0, req_reg.release_start});

    logic in_range;
    assign in_range = idx_reg < total_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ffra_pkg::S_IDLE:
                if (req_valid && init_done_reg)
                begin
                    if (req.mode == ffra_pkg::MODE_CLEAR || req.mode == ffra_pkg::MODE_UNDEF ||
                        req.slot_count == 17'd0)
                        state_next = ffra_pkg::S_OUT;
                    else
                        state_next = ffra_pkg::S_RD;
                end
            ffra_pkg::S_RD:
            begin
                if (in_range)
                    state_next = ffra_pkg::S_CHK;
                else if (req_reg.mode == ffra_pkg::MODE_ALLOC)
                    state_next = ffra_pkg::S_OUT;
                else
                    state_next = ffra_pkg::S_PREV;
            end
            ffra_pkg::S_CHK:
            begin
                if (req_reg.mode == ffra_pkg::MODE_ALLOC)
                begin
                    if (rlen >= req_reg.slot_count)
                        state_next = (rlen == req_reg.slot_count) ?
                                     ffra_pkg::S_SHL_RD : ffra_pkg::S_OUT;
                    else
                        state_next = ffra_pkg::S_RD;
                end
                else if (rbegin < req_reg.release_start)
                    state_next = ffra_pkg::S_RD;
                else
                    state_next = ffra_pkg::S_PREV;
            end
            ffra_pkg::S_PREV:
            begin
                if (prv_hit)
                    state_next = nxt_hit ? ffra_pkg::S_SHL_RD : ffra_pkg::S_OUT;
                else if (nxt_hit)
                    state_next = ffra_pkg::S_OUT;
                else if (total_reg >= MAXC)
                    state_next = ffra_pkg::S_OUT;
                else
                    state_next = (total_reg > pos_reg) ? ffra_pkg::S_SHR_RD : ffra_pkg::S_OUT;
            end
            ffra_pkg::S_SHL_RD:
                state_next = (idx_reg < total_reg) ? ffra_pkg::S_SHL_WR : ffra_pkg::S_OUT;
            ffra_pkg::S_SHL_WR: state_next = ffra_pkg::S_SHL_RD;
            ffra_pkg::S_SHR_RD: state_next = ffra_pkg::S_SHR_WR;
            ffra_pkg::S_SHR_WR:
                state_next = (idx_reg == pos_reg + ONE) ? ffra_pkg::S_OUT : ffra_pkg::S_SHR_RD;
            ffra_pkg::S_OUT:  if (rsp_ready) state_next = ffra_pkg::S_IDLE;
            default:          state_next = ffra_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        req_next = req_reg; total_next = total_reg; idx_next = idx_reg;
        pos_next = pos_reg; pb_next = pb_reg; pl_next = pl_reg;
        nb_next = nb_reg; nl_next = nl_reg; rsp_next = rsp_reg;
        we = 1'b0; waddr = '0; wbegin = '0; wlen = '0; raddr = idx_reg[AW-1:0];
        req_ready = 1'b0; rsp_valid = 1'b0;
        case (state_reg)
            ffra_pkg::S_IDLE:
            begin
                req_ready = init_done_reg;
                if (req_valid && init_done_reg)
                begin
                    req_next = req; idx_next = '0; pos_next = '0;
                    rsp_next = '{granted_start: 16'd0, status: ffra_pkg::ST_REJECT};
                    if (req.mode == ffra_pkg::MODE_CLEAR)
                    begin
                        // rewrite entry 0 and drop the rest
                        we = 1'b1; wlen = FULL_LEN; total_next = ONE;
                        rsp_next.status = ffra_pkg::ST_DONE;
                    end
                end
            end
            ffra_pkg::S_RD: ;   // memory read of idx in flight
            ffra_pkg::S_CHK:
            begin
                if (req_reg.mode == ffra_pkg::MODE_ALLOC)
                begin
                    if (rlen >= req_reg.slot_count)
                    begin
                        // carve from the front
                        we = 1'b1; waddr = idx_reg[AW-1:0];
                        wbegin = sum_y[15:0]; wlen = rlen - req_reg.slot_count;
                        rsp_next = '{granted_start: rbegin, status: ffra_pkg::ST_DONE};
                        if (rlen == req_reg.slot_count) total_next = total_reg - ONE;
                    end
                    else
                        idx_next = idx_reg + ONE;
                end
                else if (rbegin < req_reg.release_start)
                begin
                    pb_next = rbegin; pl_next = rlen; idx_next = idx_reg + ONE;
                    pos_next = idx_reg + ONE;
                end
                else
                begin
                    nb_next = rbegin; nl_next = rlen;
                end
            end
            ffra_pkg::S_PREV:
            begin
                // pos_reg = insert point; nb/nl valid when pos < total
                rsp_next.status = ffra_pkg::ST_DONE;
                if (prv_hit)
                begin
                    we = 1'b1; waddr = AW'(pos_reg - ONE); wbegin = pb_reg;
                    if (nxt_hit)
                    begin
                        wlen = sat({1'b0, sat({1'b0, pl_reg} + {1'b0, req_reg.slot_count})}
                                   + {1'b0, nl_reg});
                        idx_next = pos_reg; total_next = total_reg - ONE;
                    end
                    else
                        wlen = sat({1'b0, pl_reg} + {1'b0, req_reg.slot_count});
                end
                else if (nxt_hit)
                begin
                    we = 1'b1; waddr = pos_reg[AW-1:0]; wbegin = req_reg.release_start;
                    wlen = sat({1'b0, nl_reg} + {1'b0, req_reg.slot_count});
                end
                else if (total_reg >= MAXC)
                    rsp_next.status = ffra_pkg::ST_FULL;
                else
                begin
                    // write new run; displaced entries shift up from the top
                    total_next = total_reg + ONE;
                    idx_next = total_reg;
                    if (total_reg == pos_reg)
                    begin
                        we = 1'b1; waddr = pos_reg[AW-1:0];
                        wbegin = req_reg.release_start; wlen = req_reg.slot_count;
                    end
                end
            end
            // remove: entry idx <= entry idx+1 (total already decremented)
            ffra_pkg::S_SHL_RD: raddr = AW'(idx_reg + ONE);
            ffra_pkg::S_SHL_WR:
            begin
                we = 1'b1; waddr = idx_reg[AW-1:0]; wbegin = rbegin; wlen = rlen;
                idx_next = idx_reg + ONE;
            end
            // insert: entry idx <= entry idx-1, down to pos+1, then new run at pos
            ffra_pkg::S_SHR_RD: raddr = AW'(idx_reg - ONE);
            ffra_pkg::S_SHR_WR:
            begin
                we = 1'b1; waddr = idx_reg[AW-1:0]; wbegin = rbegin; wlen = rlen;
                idx_next = idx_reg - ONE;
            end
            ffra_pkg::S_OUT:
                rsp_valid = 1'b1;
            default: ;
        endcase
    end

    // new-run write after an up-shift uses a dedicated cycle on entry to OUT
    logic ins_pend_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ins_pend_reg <= 1'b0;
        else
            ins_pend_reg <= (state_reg == ffra_pkg::S_SHR_WR) && (idx_reg == pos_reg + ONE);
    end

    logic          we_m;
    logic [AW-1:0] waddr_m;
    logic [15:0]   wbegin_m;
    logic [16:0]   wlen_m;
    always_comb
    begin
        we_m = we; waddr_m = waddr; wbegin_m = wbegin; wlen_m = wlen;
        if (ins_pend_reg)
        begin
            we_m = 1'b1; waddr_m = pos_reg[AW-1:0];
            wbegin_m = req_reg.release_start; wlen_m = req_reg.slot_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ffra_pkg::S_IDLE;
            total_reg <= ONE;
        end
        else
        begin
            state_reg <= state_next;
            total_reg <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next; idx_reg <= idx_next; pos_reg <= pos_next;
        pb_reg <= pb_next; pl_reg <= pl_next; nb_reg <= nb_next; nl_reg <= nl_next;
        rsp_reg <= rsp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            init_done_reg <= 1'b0;
        else
            init_done_reg <= 1'b1;
    end

    logic          we_t;
    logic [AW-1:0] waddr_t;
    logic [15:0]   wbegin_t;
    logic [16:0]   wlen_t;
    always_comb
    begin
        we_t = we_m; waddr_t = waddr_m; wbegin_t = wbegin_m; wlen_t = wlen_m;
        if (!init_done_reg)
        begin
            we_t = 1'b1; waddr_t = '0; wbegin_t = '0; wlen_t = FULL_LEN;
        end
    end

    ffra_table #(.MAX_RUNS(MAX_RUNS)) u_table (
        .clk(clk), .we(we_t), .waddr(waddr_t), .wbegin(wbegin_t), .wlen(wlen_t),
        .raddr(raddr), .rbegin(rbegin), .rlen(rlen)
    );

    assign rsp = rsp_reg;
endmodule
`default_nettype wire

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: first-fit run allocator bench
// Drives allocate, release, clear and undefined-mode requests with random
// idle gaps, predicts each result from a private copy of the free-run table,
// and checks every response field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

// Scoreboard: own copy of the free-run table plus a queue of pending results.
class run_table_board;
    localparam int RUNS  = ffra_pkg::MAX_RUNS_DEF;
    localparam int SLOTS = ffra_pkg::TOTAL_SLOTS_DEF;

    logic [15:0]    begins [RUNS];
    logic [16:0]    lengths[RUNS];
    int             count;
    ffra_pkg::rsp_t pending[$];
    int             errors;

    function new();
        errors = 0;
        wipe();
    endfunction

    function void wipe();
        for (int i = 0; i < RUNS; i++)
        begin
            begins[i]  = '0;
            lengths[i] = '0;
        end
        lengths[0] = 17'(SLOTS);
        count      = 1;
    endfunction

    function logic [16:0] sat(logic [17:0] s);
        return (s > 18'h1FFFF) ? 17'h1FFFF : s[16:0];
    endfunction

    function void drop_at(int p);
        for (int i = p; i + 1 < count; i++)
        begin
            begins[i]  = begins[i+1];
            lengths[i] = lengths[i+1];
        end
        count--;
    endfunction

    function ffra_pkg::rsp_t grant(logic [16:0] n);
        ffra_pkg::rsp_t r;
        r = '{granted_start: '0, status: ffra_pkg::ST_REJECT};
        if (n == 0) return r;
        for (int i = 0; i < count; i++)
        begin
            if (lengths[i] < n) continue;
            r.granted_start = begins[i];
            r.status        = ffra_pkg::ST_DONE;
            begins[i]       = 16'(begins[i] + n);
            lengths[i]      = lengths[i] - n;
            if (lengths[i] == 0) drop_at(i);
            return r;
        end
        return r;
    endfunction

    function logic [1:0] give_back(logic [15:0] s, logic [16:0] n);
        int p;
        bit nxt, prv;
        p = 0;
        if (n == 0) return ffra_pkg::ST_REJECT;
        while (p < count && begins[p] < s) p++;
        // touch tests compare without wrapping
        nxt = p < count && (18'(s) + 18'(n)) == 18'(begins[p]);
        prv = p > 0 && (18'(begins[p-1]) + 18'(lengths[p-1])) == 18'(s);
        if (nxt && prv)
        begin
            lengths[p-1] = sat(18'(sat(18'(lengths[p-1]) + 18'(n)))
                               + 18'(lengths[p]));
            drop_at(p);
        end
        else if (nxt)
        begin
            begins[p]  = s;
            lengths[p] = sat(18'(lengths[p]) + 18'(n));
        end
        else if (prv)
            lengths[p-1] = sat(18'(lengths[p-1]) + 18'(n));
        else
        begin
            if (count >= RUNS) return ffra_pkg::ST_FULL;
            for (int i = count; i > p; i--)
            begin
                begins[i]  = begins[i-1];
                lengths[i] = lengths[i-1];
            end
            begins[p]  = s;
            lengths[p] = n;
            count++;
        end
        return ffra_pkg::ST_DONE;
    endfunction

    // Note an accepted request and queue its expected result.
    function void note_request(ffra_pkg::req_t q);
        ffra_pkg::rsp_t r;
        r = '{granted_start: '0, status: ffra_pkg::ST_REJECT};
        case (q.mode)
            ffra_pkg::MODE_ALLOC:   r = grant(q.slot_count);
            ffra_pkg::MODE_RELEASE: r.status = give_back(q.release_start, q.slot_count);
            ffra_pkg::MODE_CLEAR:
            begin
                wipe();
                r.status = ffra_pkg::ST_DONE;
            end
            default: ;
        endcase
        pending.push_back(r);
    endfunction

    function void check_result(ffra_pkg::rsp_t a);
        ffra_pkg::rsp_t e;
        if (pending.size() == 0)
        begin
            $error("unexpected result %h", a);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (a.granted_start !== e.granted_start)
        begin
            $error("granted_start: expected %h actual %h", e.granted_start, a.granted_start);
            errors++;
        end
        if (a.status !== e.status)
        begin
            $error("status: expected %h actual %h", e.status, a.status);
            errors++;
        end
    endfunction
endclass

module tb_top;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    ffra_pkg::req_t req;
    logic rsp_valid;
    logic rsp_ready;
    ffra_pkg::rsp_t rsp;

    run_table_board board;
    bit   sending_done;
    bit   calm;          // stretch with no idling on either side
    int   requests_sent;
    logic [15:0] held[$]; // begins of granted runs
    logic [16:0] held_n[$];

    first_fit_run_allocator_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req(req),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Send one request: drive at the falling edge, hold until accepted.
    task automatic send_request(logic [1:0] m, logic [15:0] s, logic [16:0] n);
        ffra_pkg::req_t q;
        q = '{mode: m, release_start: s, slot_count: n};
        while (!calm && $urandom_range(99) < 17)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req       <= q;
        req_valid <= 1'b1;
        do @(posedge clk); while (!req_ready);
        board.note_request(q);
        if (m == ffra_pkg::MODE_ALLOC && n != 0 && n < 4096)
        begin
            // remember a plausible run so later releases can merge
            held.push_back(16'(board.pending[$].granted_start));
            held_n.push_back(n);
        end
        requests_sent++;
        @(negedge clk);
    endtask

    // Mostly small allocations and releases of previously granted runs.
    task automatic random_request();
        int k, pick;
        k = $urandom_range(99);
        if (k < 2)
            send_request(ffra_pkg::MODE_CLEAR, 16'($urandom), 17'($urandom));
        else if (k < 4)
            send_request(ffra_pkg::MODE_UNDEF, 16'($urandom), 17'($urandom));
        else if (k < 45)
            send_request(ffra_pkg::MODE_ALLOC, 16'($urandom),
                         ($urandom_range(19) == 0) ? 17'($urandom) : 17'($urandom_range(64)));
        else if (k < 85 && held.size() > 0)
        begin
            pick = $urandom_range(held.size() - 1);
            send_request(ffra_pkg::MODE_RELEASE, held[pick], held_n[pick]);
            held.delete(pick);
            held_n.delete(pick);
        end
        else
            send_request(ffra_pkg::MODE_RELEASE, 16'($urandom),
                         ($urandom_range(9) == 0) ? 17'($urandom) : 17'($urandom_range(40)));
    endtask

    initial
    begin
        board         = new();
        req_valid     = 1'b0;
        req           = '0;
        rst_n         = 1'b0;
        sending_done  = 1'b0;
        calm          = 1'b0;
        requests_sent = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: extremes, every mode, zero count, no fit, merges.
        send_request(ffra_pkg::MODE_ALLOC, 16'hFFFF, 17'd0);
        send_request(ffra_pkg::MODE_RELEASE, 16'h0000, 17'd0);
        send_request(ffra_pkg::MODE_ALLOC, 16'h0000, 17'h10001);
        send_request(ffra_pkg::MODE_ALLOC, 16'h0000, 17'h10000);
        send_request(ffra_pkg::MODE_ALLOC, 16'h0000, 17'd1);
        send_request(ffra_pkg::MODE_RELEASE, 16'h0010, 17'd16);
        send_request(ffra_pkg::MODE_RELEASE, 16'h0000, 17'd16);
        send_request(ffra_pkg::MODE_RELEASE, 16'h0020, 17'd16);
        send_request(ffra_pkg::MODE_RELEASE, 16'hFFFF, 17'h1FFFF);
        send_request(ffra_pkg::MODE_UNDEF, 16'hFFFF, 17'h1FFFF);
        send_request(ffra_pkg::MODE_CLEAR, 16'h0000, 17'd0);
        send_request(ffra_pkg::MODE_ALLOC, 16'h0000, 17'h0FFFF);
        send_request(ffra_pkg::MODE_RELEASE, 16'h0000, 17'h1FFFF);
        send_request(ffra_pkg::MODE_CLEAR, 16'h0000, 17'd0);
        // Fill the table: allocate all, then release isolated single slots.
        send_request(ffra_pkg::MODE_ALLOC, 16'h0000, 17'h10000);
        for (int i = 0; i < 66; i++)
            send_request(ffra_pkg::MODE_RELEASE, 16'(i * 4), 17'd1);
        send_request(ffra_pkg::MODE_RELEASE, 16'd1, 17'd1); // merge while full
        send_request(ffra_pkg::MODE_CLEAR, 16'h0000, 17'd0);

        // Random, with a calm stretch in the middle.
        for (int i = 0; i < 1800; i++)
        begin
            calm = (i >= 600 && i < 800);
            random_request();
        end
        calm = 1'b0;
        req_valid <= 1'b0;
        sending_done = 1'b1;
    end

    // Receiver: random stalls, one long hold-off, checks at the rising edge.
    initial
    begin
        int hold;
        bit stall_done;
        stall_done = 1'b0;
        rsp_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (requests_sent >= 40 && !stall_done)
            begin
                // hold off long enough for the sender to back up
                stall_done = 1'b1;
                rsp_ready <= 1'b0;
                for (hold = 0; hold < 600; hold++) @(negedge clk);
            end
            rsp_ready <= calm || ($urandom_range(99) >= 17);
        end
    end

    always @(posedge clk)
        if (rst_n && rsp_valid && rsp_ready)
            board.check_result(rsp);

    initial
    begin
        wait (sending_done);
        while (board.pending.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("== FAIL ==");
        $finish;
    end
endmodule
`default_nettype wire

### first_fit_run_allocator_unit.f
hw/rtl/ffra_pkg.sv
hw/rtl/ffra_table.sv
hw/rtl/first_fit_run_allocator_unit.sv
bench/tb_top.sv
